[rtl/stdc_pkg.sv]
// Shared types and constants for the settable time-of-day clock.
// No dependencies; compile first.
`default_nettype none

package stdc_pkg;

  // Field widths
  localparam int unsigned PreW   = 16;
  localparam int unsigned HourW  = 5;
  localparam int unsigned MinW   = 6;
  localparam int unsigned SecW   = 6;
  localparam int unsigned BtnW   = 2;
  localparam int unsigned DownsW = 4;
  localparam int unsigned HeldW  = 3;

  // Buttons that exist on the board; higher levels read as released
  localparam int unsigned NumButtons = 4;

  // Field limits
  localparam logic [SecW-1:0]  MaxSeconds = SecW'(59);
  localparam logic [MinW-1:0]  MaxMinutes = MinW'(59);
  localparam logic [HourW-1:0] MaxHours   = HourW'(23);

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgTicksPerSecond = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgTicksPerRepeat = 1'b1;

  // Reset values of the reload registers
  localparam logic [PreW-1:0] TicksPerSecondRst = PreW'(100);
  localparam logic [PreW-1:0] TicksPerRepeatRst = PreW'(50);

  // Item kind codes
  localparam logic KindTick   = 1'b0;
  localparam logic KindButton = 1'b1;

  // Button index to time field
  localparam logic [BtnW-1:0] BtnSeconds = 2'd0;
  localparam logic [BtnW-1:0] BtnMinutes = 2'd1;
  localparam logic [BtnW-1:0] BtnHours   = 2'd2;

  typedef struct packed {
    logic              kind;
    logic [BtnW-1:0]   button;
    logic [DownsW-1:0] buttons_down;
    logic              count_up;
  } stdc_in_t;

  typedef struct packed {
    logic [HourW-1:0] hours;
    logic [MinW-1:0]  minutes;
    logic [SecW-1:0]  seconds;
    logic             updated;
  } stdc_out_t;

endpackage

`default_nettype wire

[rtl/stdc_if.sv]
// Valid/ready channel interfaces for input events and time results.
// Depends on stdc_pkg.
`default_nettype none

interface stdc_in_if;
  import stdc_pkg::*;

  logic     valid;
  logic     ready;
  stdc_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface stdc_out_if;
  import stdc_pkg::*;

  logic      valid;
  logic      ready;
  stdc_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/settable_time_of_day_clock_core.sv]
// Top level of the settable 24-hour HH:MM:SS clock.
// Depends on stdc_pkg and the channel interfaces in stdc_if.
//
//   channel  | dir | payload                                 | handshake
//   ---------+-----+-----------------------------------------+------------
//   in_if    | in  | kind, button, buttons_down, count_up    | valid/ready
//   out_if   | out | hours, minutes, seconds, updated        | valid/ready
//   cfg      | in  | cfg_idx_i, cfg_data_i                   | cfg_we_i
//
// One item per cycle unless out_if stalls; each item passes the input
// register, then the result register. The time and prescaler update is
// combinational between them. Reset loads 00:00:00 and the reset reload
// values. A stalled result holds the result register; the input register
// keeps taking items while the result register is free or being drained.
`default_nettype none

module settable_time_of_day_clock_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  stdc_in_if.sink                      in_if,
  stdc_out_if.source                   out_if,
  input  wire                          cfg_we_i,
  input  wire [stdc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire [stdc_pkg::CfgDataW-1:0] cfg_data_i
);
  import stdc_pkg::*;

  // Step a field up or down with wrap at its limit
  function automatic logic [SecW-1:0] step_fld(logic [SecW-1:0] f, logic [SecW-1:0] top,
                                               logic up);
    logic [SecW-1:0] r;
    if (up) begin
      r = (f >= top) ? '0 : f + 1'b1;
    end else begin
      r = (f == '0 || f > top) ? top : f - 1'b1;
    end
    return r;
  endfunction

  // Configuration registers
  logic [PreW-1:0] tps_q, tpr_q;

  // Clock state
  logic [SecW-1:0]  sec_q, sec_d;
  logic [MinW-1:0]  min_q, min_d;
  logic [HourW-1:0] hour_q, hour_d;
  logic [PreW-1:0]  pre_q, pre_d;
  logic [HeldW-1:0] held_cnt_q, held_cnt_d;
  logic [BtnW-1:0]  held_btn_q, held_btn_d;

  // Pipeline registers
  logic      in_vld_q;
  stdc_in_t  in_q;
  logic      out_vld_q;
  stdc_out_t out_q;
  logic      upd;

  logic            out_free;
  logic            fire;
  logic [PreW-1:0] pre_dec;
  logic [HeldW-1:0] others;
  logic            lvl;

  assign out_free     = !out_vld_q || out_if.ready;
  assign fire         = in_vld_q && out_free;
  assign in_if.ready  = !in_vld_q || out_free;
  assign out_if.valid = out_vld_q;
  assign out_if.data  = out_q;
  assign pre_dec      = pre_q - 1'b1;

  // Compute next time and prescaler for the item in the input register
  always_comb begin
    sec_d      = sec_q;
    min_d      = min_q;
    hour_d     = hour_q;
    pre_d      = pre_q;
    held_cnt_d = held_cnt_q;
    held_btn_d = held_btn_q;
    upd        = 1'b0;
    others     = '0;
    lvl        = 1'b0;
    if (in_q.kind == KindTick) begin
      if (held_cnt_q == '0) begin
        pre_d = pre_dec;
        if (pre_dec == '0) begin
          // advance one second with carry
          sec_d = step_fld(sec_q, MaxSeconds, 1'b1);
          if (sec_q >= MaxSeconds) begin
            min_d = step_fld(min_q, MaxMinutes, 1'b1);
            if (min_q >= MaxMinutes) begin
              hour_d = HourW'(step_fld(SecW'(hour_q), SecW'(MaxHours), 1'b1));
            end
          end
          upd   = 1'b1;
          pre_d = tps_q;
        end
      end else if (held_cnt_q == HeldW'(1)) begin
        pre_d = pre_dec;
        if (pre_dec == '0 && held_btn_q < 2'd3) begin
          // auto-repeat step of the held field
          case (held_btn_q)
            BtnSeconds: sec_d  = step_fld(sec_q, MaxSeconds, in_q.count_up);
            BtnMinutes: min_d  = step_fld(min_q, MaxMinutes, in_q.count_up);
            default:    hour_d = HourW'(step_fld(SecW'(hour_q), SecW'(MaxHours),
                                                 in_q.count_up));
          endcase
          upd   = 1'b1;
          pre_d = tpr_q;
        end
      end
    end else begin
      // count the other held buttons, remembering the highest one
      for (int i = 0; i < DownsW; i++) begin
        if (i < NumButtons && i != int'(in_q.button) && in_q.buttons_down[i]) begin
          held_btn_d = BtnW'(i);
          others     = others + 1'b1;
        end
      end
      held_cnt_d = others;
      lvl = (int'(in_q.button) < NumButtons) && in_q.buttons_down[in_q.button];
      if (lvl) begin
        if (others == '0 && in_q.button < 2'd3) begin
          case (in_q.button)
            BtnSeconds: sec_d  = step_fld(sec_q, MaxSeconds, in_q.count_up);
            BtnMinutes: min_d  = step_fld(min_q, MaxMinutes, in_q.count_up);
            default:    hour_d = HourW'(step_fld(SecW'(hour_q), SecW'(MaxHours),
                                                 in_q.count_up));
          endcase
          upd = 1'b1;
        end
        held_btn_d = in_q.button;
        held_cnt_d = others + 1'b1;
      end
      pre_d = tps_q;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= TicksPerSecondRst;
      tpr_q <= TicksPerRepeatRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgTicksPerSecond: tps_q <= cfg_data_i;
        CfgTicksPerRepeat: tpr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clock state update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sec_q      <= '0;
      min_q      <= '0;
      hour_q     <= '0;
      pre_q      <= TicksPerSecondRst;
      held_cnt_q <= '0;
      held_btn_q <= '0;
    end else if (fire) begin
      sec_q      <= sec_d;
      min_q      <= min_d;
      hour_q     <= hour_d;
      pre_q      <= pre_d;
      held_cnt_q <= held_cnt_d;
      held_btn_q <= held_btn_d;
    end
  end

  // Input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  // Input register payload
  always_ff @(posedge clk_i) begin
    if (in_if.ready && in_if.valid) begin
      in_q <= in_if.data;
    end
  end

  // Result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_free) begin
      out_vld_q <= in_vld_q;
    end
  end

  // Result register payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q.hours   <= hour_d;
      out_q.minutes <= min_d;
      out_q.seconds <= sec_d;
      out_q.updated <= upd;
    end
  end

endmodule

`default_nettype wire
